/* rtl/zste_pkg.sv */
package zste_pkg;

   // controller states
   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_RUN  = 1'b1;

   // fixed fractional width of the 11.16 and 12.16 tile positions
   localparam int FRAC_BITS = 16;

   // controller -> datapath
   typedef struct packed {
      logic load;   // latch a new sprite entry, clear tile counters
      logic emit;   // write the current tile into the output register, advance
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;   // current tile is the final one of the entry
   } status_type;

endpackage

/* rtl/zste_ctrl.sv */
module zste_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_first_in_chain,
   input  logic [3:0]          req_priority_pass,
   input  logic [3:0]          req_size_priority,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  zste_pkg::status_type status,
   output zste_pkg::cmd_type    cmd
);
   import zste_pkg::*;

   logic state_ff, state_in;
   logic chain_stopped_ff, chain_stopped_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, stopped_eff, mismatch, out_free, emit;

   assign req_stall   = (state_ff != STATE_IDLE);
   assign accept      = req_valid && !req_stall;
   assign stopped_eff = chain_stopped_ff && !req_first_in_chain;
   assign mismatch    = (req_size_priority != req_priority_pass);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign emit        = (state_ff == STATE_RUN) && out_free;

   assign cmd.load  = accept && !stopped_eff && !mismatch;
   assign cmd.emit  = emit;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      chain_stopped_in = chain_stopped_ff;
      if (accept) begin
         chain_stopped_in = stopped_eff | mismatch;
      end
      case (state_ff)
         STATE_IDLE: begin
            if (cmd.load) begin
               state_in = STATE_RUN;
            end
         end
         STATE_RUN: begin
            if (emit && status.last) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
      if (out_free) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= STATE_IDLE;
         chain_stopped_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         chain_stopped_ff <= chain_stopped_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

endmodule

/* rtl/zste_datapath.sv */
module zste_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  zste_pkg::cmd_type    cmd,
   output zste_pkg::status_type status,
   input  logic [15:0]          req_offset_x,
   input  logic [15:0]          req_offset_y,
   input  logic [15:0]          req_tile_code,
   input  logic [15:0]          req_attribute,
   input  logic [15:0]          req_pos_x,
   input  logic [15:0]          req_pos_y,
   input  logic [15:0]          req_zoom,
   input  logic [15:0]          req_size_word,
   output logic [14:0]          rsp_out_code,
   output logic [23:0]          rsp_palette_offset,
   output logic signed [11:0]   rsp_screen_x,
   output logic signed [12:0]   rsp_screen_y,
   output logic                 rsp_flip_x,
   output logic                 rsp_flip_y,
   output logic [20:0]          rsp_scale_x,
   output logic [21:0]          rsp_scale_y,
   output logic                 rsp_last_tile
);
   import zste_pkg::*;

   logic bias_en_ff;

   // per-entry values, computed at load
   logic [14:0]        code_ff;
   logic [23:0]        pal_ff;
   logic signed [9:0]  sx_ff;
   logic signed [10:0] sy_ff;
   logic [24:0]        xdim_ff, ydim_ff;
   logic [1:0]         xmax_ff;
   logic [2:0]         ymax_ff;
   logic               fx_ff, fy_ff;
   logic [20:0]        xscale_ff;
   logic [21:0]        yscale_ff;

   logic [1:0] col_cnt_ff;
   logic [2:0] row_cnt_ff;
   logic [4:0] tile_cnt_ff;

   // load-side logic
   logic [9:0]         wx, wy;
   logic signed [10:0] sy_in;
   logic [1:0]         xs_in, ys_in;
   logic [8:0]         zx_p1, zy_p1;
   logic [24:0]        xdim_in, ydim_in;
   logic [20:0]        xsc_raw;
   logic [21:0]        ysc_raw;

   // tile-side logic
   logic [1:0]         col;
   logic [2:0]         row;
   logic [26:0]        xoff;
   logic [27:0]        yoff;
   logic signed [26:0] nx;
   logic signed [27:0] ny;
   logic signed [10:0] qx;
   logic signed [11:0] qy;
   logic               last;

   // output register
   logic [14:0]        out_code_ff;
   logic [23:0]        pal_out_ff;
   logic signed [11:0] screen_x_ff;
   logic signed [12:0] screen_y_ff;
   logic               flip_x_ff, flip_y_ff;
   logic [20:0]        scale_x_ff;
   logic [21:0]        scale_y_ff;
   logic               last_ff;

   always_comb begin
      wx    = req_pos_x[9:0] + req_offset_x[9:0];
      wy    = req_pos_y[9:0] + req_offset_y[9:0];
      sy_in = -$signed({wy[9], wy});
      if (bias_en_ff) begin
         sy_in = sy_in + 11'sd256;
      end
      case (req_size_word[1:0])
         2'd2:    xs_in = 2'd1;
         2'd3:    xs_in = 2'd2;
         default: xs_in = 2'd0;
      endcase
      ys_in   = req_size_word[3:2];
      zx_p1   = {1'b0, req_zoom[7:0]} + 9'd1;
      zy_p1   = {1'b0, req_zoom[15:8]} + 9'd1;
      xdim_in = {zx_p1, 16'b0} >> xs_in;
      ydim_in = {zy_p1, 16'b0} >> ys_in;
      xsc_raw = xdim_in[24:4];
      ysc_raw = ydim_in[24:3];
   end

   // tile position: signed 11.16 (x) and 12.16 (y) sum, truncated toward zero
   always_comb begin
      col  = fx_ff ? (xmax_ff - col_cnt_ff) : col_cnt_ff;
      row  = fy_ff ? (ymax_ff - row_cnt_ff) : row_cnt_ff;
      xoff = 27'(xdim_ff) * 27'(col);
      yoff = 28'(ydim_ff) * 28'(row);
      nx   = $signed({sx_ff[9], sx_ff, 16'b0}) + $signed(xoff);
      ny   = $signed({sy_ff[10], sy_ff, 16'b0}) + $signed(yoff);
      qx   = nx[26:FRAC_BITS];
      qy   = ny[27:FRAC_BITS];
      if (nx[26] && (nx[FRAC_BITS-1:0] != '0)) begin
         qx = qx + 11'sd1;
      end
      if (ny[27] && (ny[FRAC_BITS-1:0] != '0)) begin
         qy = qy + 12'sd1;
      end
      last = (col_cnt_ff == xmax_ff) && (row_cnt_ff == ymax_ff);
   end

   assign status.last = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         bias_en_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff   <= req_tile_code[14:0];
         pal_ff    <= req_attribute[10] ? {2'b0, req_attribute, 6'b0}
                                        : {req_attribute, 8'b0};
         sx_ff     <= $signed(wx);
         sy_ff     <= sy_in;
         xdim_ff   <= xdim_in;
         ydim_ff   <= ydim_in;
         xmax_ff   <= 2'((3'd1 << xs_in) - 3'd1);
         ymax_ff   <= 3'((4'd1 << ys_in) - 4'd1);
         fx_ff     <= req_attribute[15];
         fy_ff     <= req_attribute[14];
         xscale_ff <= (xsc_raw[15:0] != '0) ? xsc_raw + 21'd4096 : xsc_raw;
         yscale_ff <= (ysc_raw[15:0] != '0) ? ysc_raw + 22'd8192 : ysc_raw;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         tile_cnt_ff <= '0;
      end else if (cmd.emit) begin
         tile_cnt_ff <= tile_cnt_ff + 5'd1;
         if (row_cnt_ff == ymax_ff) begin
            row_cnt_ff <= '0;
            col_cnt_ff <= col_cnt_ff + 2'd1;
         end else begin
            row_cnt_ff <= row_cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_code_ff <= code_ff + 15'(tile_cnt_ff);
         pal_out_ff  <= pal_ff;
         screen_x_ff <= 12'(qx);
         screen_y_ff <= 13'(qy);
         flip_x_ff   <= fx_ff;
         flip_y_ff   <= fy_ff;
         scale_x_ff  <= xscale_ff;
         scale_y_ff  <= yscale_ff;
         last_ff     <= last;
      end
   end

   assign rsp_out_code       = out_code_ff;
   assign rsp_palette_offset = pal_out_ff;
   assign rsp_screen_x       = screen_x_ff;
   assign rsp_screen_y       = screen_y_ff;
   assign rsp_flip_x         = flip_x_ff;
   assign rsp_flip_y         = flip_y_ff;
   assign rsp_scale_x        = scale_x_ff;
   assign rsp_scale_y        = scale_y_ff;
   assign rsp_last_tile      = last_ff;

endmodule

/* rtl/zoomed_sprite_tile_expander.sv */
// Zoomed sprite tile expander.
// req_ channel: one sprite entry per item (code, attribute, position, zoom,
//    size word, list header offsets, first-of-chain mark, priority pass).
// rsp_ channel: one tile draw command per item, in scan order (columns
//    outer, rows inner), last_tile set on the final command of an entry.
// csr_: single write-only bit, vertical bias enable; write while idle.
// An entry is latched at load; each tile then goes through the output register.
// Throughput: one command per cycle while the receiver does not stall; an
//    entry of N tiles (1 to 32) keeps req_stall high until its last tile is
//    emitted; the column and row counters of the datapath set N.
// An entry that is dropped (priority mismatch or stopped chain) produces
//    nothing and leaves the block idle; req_stall stays low while idle.
// The next entry is taken while the final command still waits in the
//    output register.
// rsp_stall freezes the output register and the tile counters.
// Reset (synchronous): empties the output, clears the chain stop flag and
//    the bias bit.
module zoomed_sprite_tile_expander (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_first_in_chain,
   input  logic [3:0]         req_priority_pass,
   input  logic [15:0]        req_offset_x,
   input  logic [15:0]        req_offset_y,
   input  logic [15:0]        req_tile_code,
   input  logic [15:0]        req_attribute,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [15:0]        req_zoom,
   input  logic [15:0]        req_size_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_out_code,
   output logic [23:0]        rsp_palette_offset,
   output logic signed [11:0] rsp_screen_x,
   output logic signed [12:0] rsp_screen_y,
   output logic               rsp_flip_x,
   output logic               rsp_flip_y,
   output logic [20:0]        rsp_scale_x,
   output logic [21:0]        rsp_scale_y,
   output logic               rsp_last_tile
);
   import zste_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing, chain stop tracking, output valid
   zste_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_in_chain (req_first_in_chain),
      .req_priority_pass  (req_priority_pass),
      .req_size_priority  (req_size_word[7:4]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .status             (status),
      .cmd                (cmd)
   );

   // per-entry setup, tile counters, position math, output register
   zste_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .cmd                (cmd),
      .status             (status),
      .req_offset_x       (req_offset_x),
      .req_offset_y       (req_offset_y),
      .req_tile_code      (req_tile_code),
      .req_attribute      (req_attribute),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_zoom           (req_zoom),
      .req_size_word      (req_size_word),
      .rsp_out_code       (rsp_out_code),
      .rsp_palette_offset (rsp_palette_offset),
      .rsp_screen_x       (rsp_screen_x),
      .rsp_screen_y       (rsp_screen_y),
      .rsp_flip_x         (rsp_flip_x),
      .rsp_flip_y         (rsp_flip_y),
      .rsp_scale_x        (rsp_scale_x),
      .rsp_scale_y        (rsp_scale_y),
      .rsp_last_tile      (rsp_last_tile)
   );

endmodule
